// ===== hw/rtl/sots_pkg.sv =====
package sots_pkg;

   // Width of the request value port.
   localparam int TARGET_WIDTH = 31;

   // Control between the sequencer and the root unit.
   typedef struct packed {
      logic start;
      logic done;
   } sots_root_ctl_type;

endpackage

// ===== hw/rtl/sots_isqrt.sv =====
// Floor square root, two value bits per cycle; rem_o = value - root_o^2.
module sots_isqrt
   import sots_pkg::*;
#(
   parameter int ROOT_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [2*ROOT_WIDTH-1:0] value,
   output sots_root_ctl_type       ctl,
   output logic [ROOT_WIDTH-1:0]   root_o,
   output logic [ROOT_WIDTH+1:0]   rem_o
);

   localparam int RW = ROOT_WIDTH;
   localparam int CW = $clog2(RW + 1);

   logic [2*RW-1:0] val_ff, val_in;
   logic [RW+1:0]   rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            running_ff, running_in;
   logic            done_ff, done_in;

   logic [RW+2:0]   rem_sh;
   logic [RW+2:0]   trial;
   logic [RW+2:0]   diff;
   logic            ge;
   logic [RW:0]     root_wide;

   assign rem_sh    = {rem_ff[RW:0], val_ff[2*RW-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign ge        = (rem_sh >= trial);
   assign diff      = rem_sh - trial;
   assign root_wide = {root_ff, ge};

   always_comb begin
      val_in     = val_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      cnt_in     = cnt_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (start) begin
         // load a new value, clear the partial root
         val_in     = value;
         rem_in     = '0;
         root_in    = '0;
         cnt_in     = CW'(RW);
         running_in = 1'b1;
      end else if (running_ff) begin
         // retire one root bit
         val_in  = val_ff << 2;
         rem_in  = ge ? diff[RW+1:0] : rem_sh[RW+1:0];
         root_in = root_wide[RW-1:0];
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign ctl.start = start;
   assign ctl.done  = done_ff;
   assign root_o    = root_ff;
   assign rem_o     = rem_ff;

endmodule

// ===== hw/rtl/sum_of_two_squares_test.sv =====
// Sum-of-two-squares test. Pulse start with a value on req_target while busy
// is low; the request is taken at that edge and busy rises. The block takes
// the floor square root of the value on a two-bit-per-cycle root unit, then
// walks two pointers, one step per cycle, until they cross, the high pointer
// reaches zero with the sum still too large, or the squares add up to the
// value. The answer appears on rsp_is_sum, marked by rsp_valid, which is
// high for exactly one cycle; the receiver cannot stall it, so capture it in
// that cycle. busy falls in the cycle rsp_valid is high, and a new request
// may start right then.
// Only the low VALUE_WIDTH bits of req_target take part.
module sum_of_two_squares_test
   import sots_pkg::*;
#(
   parameter int VALUE_WIDTH = 31
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [TARGET_WIDTH-1:0] req_target,
   output logic                    rsp_valid,
   output logic                    rsp_is_sum
);

   localparam int RW = (VALUE_WIDTH + 1) / 2;  // root bits
   localparam int LW = RW + 1;                 // low pointer may pass the root
   localparam int DW = VALUE_WIDTH + 2;        // signed slack: value - sum

   typedef enum logic [1:0] {
      IDLE,
      ROOT,
      SEARCH
   } state_type;

   state_type              state_ff, state_in;
   logic [LW-1:0]          low_ff, low_in;
   logic [RW-1:0]          high_ff, high_in;
   logic signed [DW-1:0]   slack_ff, slack_in;
   logic                   busy_ff, busy_in;
   logic                   valid_ff, valid_in;
   logic                   is_sum_ff, is_sum_in;

   logic [2*RW-1:0]        sq_value;
   logic                   sq_start;
   sots_root_ctl_type      sq_ctl;
   logic [RW-1:0]          sq_root;
   logic [RW+1:0]          sq_rem;

   logic signed [DW-1:0]   high_term;
   logic signed [DW-1:0]   low_term;

   // Drop the value bits above VALUE_WIDTH, pad to an even width for the root.
   generate
      if (VALUE_WIDTH <= TARGET_WIDTH) begin : g_trim
         assign sq_value = (2*RW)'(req_target[VALUE_WIDTH-1:0]);
      end else begin : g_pad
         assign sq_value = (2*RW)'(req_target);
      end
   endgenerate

   assign sq_start = start & ~busy_ff;

   sots_isqrt #(
      .ROOT_WIDTH (RW)
   ) u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sq_start),
      .value  (sq_value),
      .ctl    (sq_ctl),
      .root_o (sq_root),
      .rem_o  (sq_rem)
   );

   // Slack tracks value - (low^2 + high^2). Moving high down by one adds
   // 2*high - 1 to it; moving low up by one takes 2*low + 1 from it. The root
   // remainder is exactly the slack with low = 0 and high = root.
   assign high_term = signed'(DW'({high_ff, 1'b0}) - DW'(1));
   assign low_term  = signed'(DW'({low_ff, 1'b1}));

   always_comb begin
      state_in  = state_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      slack_in  = slack_ff;
      busy_in   = busy_ff;
      valid_in  = 1'b0;
      is_sum_in = is_sum_ff;
      unique case (state_ff)
         IDLE: begin
            if (sq_ctl.start) begin
               state_in = ROOT;
               busy_in  = 1'b1;
            end
         end
         ROOT: begin
            // hold until the root unit finishes, then seed the pointers
            if (sq_ctl.done) begin
               low_in   = '0;
               high_in  = sq_root;
               slack_in = signed'(DW'(sq_rem));
               state_in = SEARCH;
            end
         end
         SEARCH: begin
            priority if (low_ff > {1'b0, high_ff}) begin
               // pointers crossed: no pair found
               valid_in  = 1'b1;
               is_sum_in = 1'b0;
               busy_in   = 1'b0;
               state_in  = IDLE;
            end else if (slack_ff == '0) begin
               valid_in  = 1'b1;
               is_sum_in = 1'b1;
               busy_in   = 1'b0;
               state_in  = IDLE;
            end else if (slack_ff < 0) begin
               // sum too large: lower the high pointer, stop at zero
               if (high_ff == '0) begin
                  valid_in  = 1'b1;
                  is_sum_in = 1'b0;
                  busy_in   = 1'b0;
                  state_in  = IDLE;
               end else begin
                  slack_in = slack_ff + high_term;
                  high_in  = high_ff - RW'(1);
               end
            end else begin
               // sum too small: advance the low pointer
               slack_in = slack_ff - low_term;
               low_in   = low_ff + LW'(1);
            end
         end
         default: begin
            state_in = IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      low_ff    <= low_in;
      high_ff   <= high_in;
      slack_ff  <= slack_in;
      is_sum_ff <= is_sum_in;
   end

   assign busy       = busy_ff;
   assign rsp_valid  = valid_ff;
   assign rsp_is_sum = is_sum_ff;

endmodule
